>>> hw/rtl/tta_pkg.sv
// ----------------------------------------------------------------------------
// tta_pkg
// Types, constants and helpers shared by the task tick time accounting block.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int unsigned TICKS_PER_SECOND_DEF = 100;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned QUANT_W  = 9;
    localparam int unsigned SECS_W   = 33;

    localparam logic [7:0] NICE_PRIORITY_BOUND = 8'd15;
    localparam logic [2:0] WARN_PERIOD         = 3'd5;
    localparam logic [DATA_W-1:0] NO_LIMIT     = '1;

    localparam logic [REG_IDX_W-1:0] REG_VIRTUAL_START    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VIRTUAL_INTERVAL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROFILE_START    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PROFILE_INTERVAL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SOFT_LIMIT       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HARD_LIMIT       = 3'd5;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_START = 1'b1;

    typedef struct packed {
        logic       action;
        logic       in_user_mode;
        logic       idle_task;
        logic [7:0] task_priority;
        logic [7:0] quantum_ticks;
    } item_t;

    typedef struct packed {
        logic nice_tick;
        logic user_tick;
        logic system_tick;
        logic virtual_alarm;
        logic profile_alarm;
        logic cpu_limit_kill;
        logic cpu_limit_warn;
        logic reschedule;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] virtual_start;
        logic [DATA_W-1:0] virtual_interval;
        logic [DATA_W-1:0] profile_start;
        logic [DATA_W-1:0] profile_interval;
        logic [DATA_W-1:0] soft_limit_seconds;
        logic [DATA_W-1:0] hard_limit_seconds;
        logic [2:0]        soft_mod5;
    } cfg_t;

    // Residue modulo five: 16 is 1 mod 5, so the nibbles sum to the same residue.
    function automatic logic [2:0] mod5_32(input logic [DATA_W-1:0] value);
        logic [6:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            acc = acc + 7'(value[4*i +: 4]);
        end
        if (acc >= 7'd80) acc = acc - 7'd80;
        if (acc >= 7'd40) acc = acc - 7'd40;
        if (acc >= 7'd20) acc = acc - 7'd20;
        if (acc >= 7'd10) acc = acc - 7'd10;
        if (acc >= 7'd5)  acc = acc - 7'd5;
        return acc[2:0];
    endfunction

endpackage

>>> hw/rtl/tta_ifs.sv
// ----------------------------------------------------------------------------
// tta_ifs
// Valid/ready stream channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tta_in_if;
    logic           valid;
    logic           ready;
    tta_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tta_out_if;
    logic             valid;
    logic             ready;
    tta_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tta_acct.sv
// ----------------------------------------------------------------------------
// tta_acct
// Accounting state and per-item update: tick counts, interval timers,
// seconds tracking for CPU limits and the scheduling quantum.
// ----------------------------------------------------------------------------
module tta_acct #(
    parameter int unsigned TICKS_PER_SECOND = tta_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  tta_pkg::item_t   item,
    input  tta_pkg::cfg_t    cfg,
    output tta_pkg::result_t res
);

    localparam int unsigned REM_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam longint unsigned WRAP_SPAN = 64'hFFFF_FFFF;
    localparam logic [tta_pkg::SECS_W-1:0] WRAP_QUOT =
        tta_pkg::SECS_W'(WRAP_SPAN / TICKS_PER_SECOND);
    localparam logic [REM_W-1:0] WRAP_REM = REM_W'(WRAP_SPAN % TICKS_PER_SECOND);
    localparam logic [REM_W-1:0] WRAP_REM_COMP =
        REM_W'(TICKS_PER_SECOND - (WRAP_SPAN % TICKS_PER_SECOND));
    localparam logic [3:0] WRAP_QUOT_MOD5 = 4'((WRAP_SPAN / TICKS_PER_SECOND) % 5);
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(TICKS_PER_SECOND - 1);

    logic [31:0]                  user_ticks_reg, user_ticks_next;
    logic [31:0]                  system_ticks_reg, system_ticks_next;
    logic [31:0]                  virtual_count_reg, virtual_count_next;
    logic [31:0]                  profile_count_reg, profile_count_next;
    logic [tta_pkg::QUANT_W-1:0]  quantum_left_reg, quantum_left_next;
    logic [tta_pkg::SECS_W-1:0]   secs_reg, secs_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [2:0]                   mod5_reg, mod5_next;

    logic        wrap;
    logic        borrow;
    logic [3:0]  mod5_tmp;
    logic [32:0] virt_step;
    logic [32:0] prof_step;

    // {alarm, next count}
    function automatic logic [32:0] step_timer(input logic [31:0] count,
                                               input logic [31:0] interval);
        logic [32:0] r;
        if (count == 32'd0)
            r = {1'b0, count};
        else if (count == 32'd1)
            r = {1'b1, interval};
        else
            r = {1'b0, count - 32'd1};
        return r;
    endfunction

    assign virt_step = step_timer(virtual_count_reg, cfg.virtual_interval);
    assign prof_step = step_timer(profile_count_reg, cfg.profile_interval);

    always_comb
    begin
        user_ticks_next    = user_ticks_reg;
        system_ticks_next  = system_ticks_reg;
        virtual_count_next = virtual_count_reg;
        profile_count_next = profile_count_reg;
        quantum_left_next  = quantum_left_reg;
        secs_next          = secs_reg;
        rem_next           = rem_reg;
        mod5_next          = mod5_reg;
        res                = '0;
        wrap               = 1'b0;
        borrow             = 1'b0;
        mod5_tmp           = '0;

        if (item.action == tta_pkg::ACTION_START)
        begin
            user_ticks_next    = '0;
            system_ticks_next  = '0;
            virtual_count_next = cfg.virtual_start;
            profile_count_next = cfg.profile_start;
            quantum_left_next  = tta_pkg::QUANT_W'(item.quantum_ticks);
            secs_next          = '0;
            rem_next           = '0;
            mod5_next          = '0;
        end
        else
        begin
            if (item.in_user_mode)
            begin
                user_ticks_next = user_ticks_reg + 32'd1;
                wrap            = (user_ticks_reg == '1);
                if (!item.idle_task)
                begin
                    if (item.task_priority < tta_pkg::NICE_PRIORITY_BOUND)
                        res.nice_tick = 1'b1;
                    else
                        res.user_tick = 1'b1;
                end
                virtual_count_next = virt_step[31:0];
                res.virtual_alarm  = virt_step[32];
            end
            else
            begin
                system_ticks_next = system_ticks_reg + 32'd1;
                wrap              = (system_ticks_reg == '1);
                res.system_tick   = !item.idle_task;
            end

            // Drop 2^32 - 1 from the total when a count wraps, else add one.
            if (wrap)
            begin
                borrow   = (rem_reg < WRAP_REM);
                rem_next = borrow ? REM_W'(rem_reg + WRAP_REM_COMP) : REM_W'(rem_reg - WRAP_REM);
                secs_next = secs_reg - WRAP_QUOT - tta_pkg::SECS_W'(borrow);
                mod5_tmp  = 4'(mod5_reg) + 4'(tta_pkg::WARN_PERIOD) - WRAP_QUOT_MOD5
                            - 4'(borrow);
                mod5_next = (mod5_tmp >= 4'(tta_pkg::WARN_PERIOD))
                            ? 3'(mod5_tmp - 4'(tta_pkg::WARN_PERIOD)) : mod5_tmp[2:0];
            end
            else if (rem_reg == REM_LAST)
            begin
                rem_next  = '0;
                secs_next = secs_reg + tta_pkg::SECS_W'(1);
                mod5_next = (mod5_reg == tta_pkg::WARN_PERIOD - 3'd1) ? 3'd0 : mod5_reg + 3'd1;
            end
            else
            begin
                rem_next = rem_reg + REM_W'(1);
            end

            res.cpu_limit_kill = (cfg.hard_limit_seconds != tta_pkg::NO_LIMIT) &&
                                 (secs_next >= tta_pkg::SECS_W'(cfg.hard_limit_seconds));
            res.cpu_limit_warn = (cfg.soft_limit_seconds != tta_pkg::NO_LIMIT) &&
                                 (rem_next == '0) &&
                                 (secs_next >= tta_pkg::SECS_W'(cfg.soft_limit_seconds)) &&
                                 (mod5_next == cfg.soft_mod5);

            profile_count_next = prof_step[31:0];
            res.profile_alarm  = prof_step[32];

            if ((quantum_left_reg == '0) || item.idle_task)
            begin
                quantum_left_next = '0;
                res.reschedule    = 1'b1;
            end
            else
            begin
                quantum_left_next = quantum_left_reg - tta_pkg::QUANT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_ticks_reg    <= '0;
            system_ticks_reg  <= '0;
            virtual_count_reg <= '0;
            profile_count_reg <= '0;
            quantum_left_reg  <= '0;
            secs_reg          <= '0;
            rem_reg           <= '0;
            mod5_reg          <= '0;
        end
        else if (advance)
        begin
            user_ticks_reg    <= user_ticks_next;
            system_ticks_reg  <= system_ticks_next;
            virtual_count_reg <= virtual_count_next;
            profile_count_reg <= profile_count_next;
            quantum_left_reg  <= quantum_left_next;
            secs_reg          <= secs_next;
            rem_reg           <= rem_next;
            mod5_reg          <= mod5_next;
        end
    end

endmodule

>>> hw/rtl/task_tick_time_accounting.sv
// ----------------------------------------------------------------------------
// task_tick_time_accounting
// Per-tick CPU time accounting of the running task, with APB register port.
//
//   Port    Kind          Width  Role
//   item    valid/ready   19     start or tick beat in
//   result  valid/ready   8      accounting flags out, one beat per item
//   APB     psel/penable  32     timer loads and CPU limits
//
// One item per cycle while the result side is not stalled; an input beat passes
// the input register, then the result register after the single-pass update.
// An input beat is taken while the result register holds a beat, as long as
// the input register can move on; a stalled result holds both stages.
// Reset clears the accounting state and sets both CPU limits to none.
// ----------------------------------------------------------------------------
module task_tick_time_accounting #(
    parameter int unsigned TICKS_PER_SECOND = tta_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tta_in_if.sink                        item,
    tta_out_if.source                     result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tta_pkg::PADDR_W-1:0]   paddr,
    input  logic [tta_pkg::DATA_W-1:0]    pwdata,
    output logic [tta_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    tta_pkg::cfg_t    cfg_reg;
    tta_pkg::item_t   item_reg;
    logic             stage_valid_reg;
    tta_pkg::result_t result_data_reg;
    logic             result_valid_reg;
    tta_pkg::result_t res;
    logic             advance;
    logic             wr_en;
    logic [tta_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[tta_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.virtual_start      <= '0;
            cfg_reg.virtual_interval   <= '0;
            cfg_reg.profile_start      <= '0;
            cfg_reg.profile_interval   <= '0;
            cfg_reg.soft_limit_seconds <= tta_pkg::NO_LIMIT;
            cfg_reg.hard_limit_seconds <= tta_pkg::NO_LIMIT;
            cfg_reg.soft_mod5          <= tta_pkg::mod5_32(tta_pkg::NO_LIMIT);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tta_pkg::REG_VIRTUAL_START:    cfg_reg.virtual_start    <= pwdata;
                tta_pkg::REG_VIRTUAL_INTERVAL: cfg_reg.virtual_interval <= pwdata;
                tta_pkg::REG_PROFILE_START:    cfg_reg.profile_start    <= pwdata;
                tta_pkg::REG_PROFILE_INTERVAL: cfg_reg.profile_interval <= pwdata;
                tta_pkg::REG_SOFT_LIMIT:
                begin
                    cfg_reg.soft_limit_seconds <= pwdata;
                    cfg_reg.soft_mod5          <= tta_pkg::mod5_32(pwdata);
                end
                tta_pkg::REG_HARD_LIMIT:       cfg_reg.hard_limit_seconds <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tta_pkg::REG_VIRTUAL_START:    prdata = cfg_reg.virtual_start;
            tta_pkg::REG_VIRTUAL_INTERVAL: prdata = cfg_reg.virtual_interval;
            tta_pkg::REG_PROFILE_START:    prdata = cfg_reg.profile_start;
            tta_pkg::REG_PROFILE_INTERVAL: prdata = cfg_reg.profile_interval;
            tta_pkg::REG_SOFT_LIMIT:       prdata = cfg_reg.soft_limit_seconds;
            tta_pkg::REG_HARD_LIMIT:       prdata = cfg_reg.hard_limit_seconds;
            default:                       prdata = '0;
        endcase
    end

    assign advance    = stage_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                stage_valid_reg <= item.valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.data;
        if (advance)
            result_data_reg <= res;
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    tta_acct #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_acct (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

endmodule

>>> hw/rtl/tta_checker.sv
// ----------------------------------------------------------------------------
// tta_checker
// Port-level checks of the task tick time accounting block, bound to the top.
// ----------------------------------------------------------------------------
module tta_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input tta_pkg::result_t result_data
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> ##2 result_valid)
        else $error("accepted item gave no result beat");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with empty result stage");

    a_one_statistic: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0({result_data.nice_tick, result_data.user_tick,
                                   result_data.system_tick}))
        else $error("more than one statistic flag in a beat");

endmodule

bind task_tick_time_accounting tta_checker u_tta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

>>> dv/tb_task_tick_time_accounting.sv
// ----------------------------------------------------------------------------
// tb_task_tick_time_accounting
// Self-checking bench for the per-tick CPU time accounting block. Task start
// and tick beats go in over the item channel and flag beats come back on the
// result channel, with random gaps and stalls on both sides. A scoreboard
// keeps its own copy of the tick counts, interval timers, quantum and
// registers, and checks every result beat field by field. The APB port moves
// the run through timer and CPU limit settings between phases, extremes among
// them, so that timer expiry, soft-limit warnings and hard-limit kills occur.
// ----------------------------------------------------------------------------
module tb_task_tick_time_accounting;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICK_RATE     = tta_pkg::TICKS_PER_SECOND_DEF;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          QUIET_LIMIT   = 1000;
    localparam int          ERROR_PRINTS  = 30;

    localparam logic [tta_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tta_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tta_pkg::PADDR_W-1:0] paddr;
    logic [tta_pkg::DATA_W-1:0]  pwdata;
    logic [tta_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    logic calm;
    int   reg_writes;

    tta_in_if  item_ch ();
    tta_out_if result_ch ();

    task_tick_time_accounting #(
        .TICKS_PER_SECOND (TICK_RATE)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    class tick_scoreboard;
        logic [tta_pkg::DATA_W-1:0]  virt_start;
        logic [tta_pkg::DATA_W-1:0]  virt_reload;
        logic [tta_pkg::DATA_W-1:0]  prof_start;
        logic [tta_pkg::DATA_W-1:0]  prof_reload;
        logic [tta_pkg::DATA_W-1:0]  soft_secs;
        logic [tta_pkg::DATA_W-1:0]  hard_secs;
        bit [31:0]                   user_ticks;
        bit [31:0]                   sys_ticks;
        bit [31:0]                   virt_left;
        bit [31:0]                   prof_left;
        bit [tta_pkg::QUANT_W-1:0]   quantum_left;
        tta_pkg::result_t            expected_q[$];
        int                          errors;
        int                          items;
        int                          starts;
        int                          checked;
        int                          warns;
        int                          kills;
        int                          virt_alarms;
        int                          prof_alarms;
        int                          rescheds;

        function new();
            virt_start  = '0;
            virt_reload = '0;
            prof_start  = '0;
            prof_reload = '0;
            soft_secs   = tta_pkg::NO_LIMIT;
            hard_secs   = tta_pkg::NO_LIMIT;
        endfunction

        function void set_reg(logic [tta_pkg::REG_IDX_W-1:0] idx,
                              logic [tta_pkg::DATA_W-1:0] value);
            case (idx)
                tta_pkg::REG_VIRTUAL_START:    virt_start  = value;
                tta_pkg::REG_VIRTUAL_INTERVAL: virt_reload = value;
                tta_pkg::REG_PROFILE_START:    prof_start  = value;
                tta_pkg::REG_PROFILE_INTERVAL: prof_reload = value;
                tta_pkg::REG_SOFT_LIMIT:       soft_secs   = value;
                tta_pkg::REG_HARD_LIMIT:       hard_secs   = value;
                default: ;
            endcase
        endfunction

        // Returns 1 when the timer runs out on this tick.
        function bit tick_timer(inout bit [31:0] left,
                                input logic [tta_pkg::DATA_W-1:0] reload);
            if (left == 0)
                return 1'b0;
            left = left - 1;
            if (left != 0)
                return 1'b0;
            left = reload;
            return 1'b1;
        endfunction

        function void note_item(tta_pkg::item_t it);
            tta_pkg::result_t r;
            bit [32:0]        total;
            bit [32:0]        secs;
            bit [32:0]        soft_lim;
            r = '0;
            items++;
            if (it.action == tta_pkg::ACTION_START)
            begin
                starts++;
                user_ticks   = '0;
                sys_ticks    = '0;
                virt_left    = virt_start;
                prof_left    = prof_start;
                quantum_left = {1'b0, it.quantum_ticks};
            end
            else
            begin
                if (it.in_user_mode)
                begin
                    user_ticks = user_ticks + 1;
                    if (!it.idle_task)
                    begin
                        if (it.task_priority < tta_pkg::NICE_PRIORITY_BOUND)
                            r.nice_tick = 1'b1;
                        else
                            r.user_tick = 1'b1;
                    end
                    r.virtual_alarm = tick_timer(virt_left, virt_reload);
                end
                else
                begin
                    sys_ticks = sys_ticks + 1;
                    if (!it.idle_task)
                        r.system_tick = 1'b1;
                end

                total    = {1'b0, user_ticks} + {1'b0, sys_ticks};
                secs     = total / 33'(TICK_RATE);
                soft_lim = {1'b0, soft_secs};

                if (hard_secs != tta_pkg::NO_LIMIT && secs >= {1'b0, hard_secs})
                    r.cpu_limit_kill = 1'b1;

                if (soft_secs != tta_pkg::NO_LIMIT && (total % 33'(TICK_RATE)) == 0)
                begin
                    if (secs == soft_lim)
                        r.cpu_limit_warn = 1'b1;
                    else if (secs > soft_lim &&
                             ((secs - soft_lim) % 33'(tta_pkg::WARN_PERIOD)) == 0)
                        r.cpu_limit_warn = 1'b1;
                end

                r.profile_alarm = tick_timer(prof_left, prof_reload);

                if (quantum_left == 0 || it.idle_task)
                begin
                    quantum_left  = '0;
                    r.reschedule  = 1'b1;
                end
                else
                begin
                    quantum_left = quantum_left - tta_pkg::QUANT_W'(1);
                end
            end
            warns       += r.cpu_limit_warn;
            kills       += r.cpu_limit_kill;
            virt_alarms += r.virtual_alarm;
            prof_alarms += r.profile_alarm;
            rescheds    += r.reschedule;
            expected_q.push_back(r);
        endfunction

        function void check_result(tta_pkg::result_t got);
            tta_pkg::result_t want;
            logic [7:0]       got_bits;
            logic [7:0]       want_bits;
            string            names[8];
            names = '{"nice_tick", "user_tick", "system_tick", "virtual_alarm",
                      "profile_alarm", "cpu_limit_kill", "cpu_limit_warn", "reschedule"};
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= ERROR_PRINTS)
                    $display("%0t: result beat %b with no item pending", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            got_bits  = got;
            want_bits = want;
            for (int i = 0; i < 8; i++)
            begin
                if (got_bits[7-i] !== want_bits[7-i])
                begin
                    errors++;
                    if (errors <= ERROR_PRINTS)
                        $display("%0t: beat %0d %s expected %b actual %b", $time, checked,
                                 names[i], want_bits[7-i], got_bits[7-i]);
                end
            end
        endfunction
    endclass

    tick_scoreboard sb;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic tta_pkg::item_t make_item(logic act, logic user, logic idle,
                                                 logic [7:0] prio, logic [7:0] quant);
        tta_pkg::item_t it;
        it.action        = act;
        it.in_user_mode  = user;
        it.idle_task     = idle;
        it.task_priority = prio;
        it.quantum_ticks = quant;
        return it;
    endfunction

    function automatic tta_pkg::item_t random_item(int start_odds);
        logic       act;
        logic [7:0] prio;
        logic [7:0] quant;
        act   = (start_odds != 0 && $urandom_range(1, start_odds) == 1)
                ? tta_pkg::ACTION_START : tta_pkg::ACTION_TICK;
        prio  = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(10, 20));
        quant = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 8));
        return make_item(act, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0), prio,
                         quant);
    endfunction

    task automatic send_item(input tta_pkg::item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_reg(input logic [tta_pkg::REG_IDX_W-1:0] idx,
                             input logic [tta_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        reg_writes++;
    endtask

    task automatic load_config(input logic [tta_pkg::DATA_W-1:0] vs,
                               input logic [tta_pkg::DATA_W-1:0] vi,
                               input logic [tta_pkg::DATA_W-1:0] ps,
                               input logic [tta_pkg::DATA_W-1:0] pi,
                               input logic [tta_pkg::DATA_W-1:0] soft_lim,
                               input logic [tta_pkg::DATA_W-1:0] hard_lim,
                               input bit spare);
        write_reg(tta_pkg::REG_VIRTUAL_START, vs);
        write_reg(tta_pkg::REG_VIRTUAL_INTERVAL, vi);
        write_reg(tta_pkg::REG_PROFILE_START, ps);
        write_reg(tta_pkg::REG_PROFILE_INTERVAL, pi);
        write_reg(tta_pkg::REG_SOFT_LIMIT, soft_lim);
        write_reg(tta_pkg::REG_HARD_LIMIT, hard_lim);
        if (spare)
        begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int start_odds, input bit fresh_task);
        for (int n = 0; n < count; n++)
            send_item(random_item((n == 0 && fresh_task) ? 1 : start_odds));
        item_ch.valid <= 1'b0;
        wait_idle();
    endtask

    // Accept monitor: note input beats and check result beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                sb.note_item(item_ch.data);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
        end
    end

    // Result side back-pressure.
    initial
    begin
        int stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        do
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        while (quiet < QUIET_LIMIT);
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, QUIET_LIMIT,
                 sb.expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        tta_pkg::item_t directed_q[$];
        sb              = new();
        calm            = 1'b0;
        reg_writes      = 0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero quantum, nice bound, idle task, timer expiry, field extremes.
        load_config(32'd2, 32'd1, 32'd3, 32'd0, 32'd0, 32'd0, 1'b0);
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd0,   8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_START, 1'b1, 1'b1, 8'd255, 8'd3));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd14,  8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd15,  8'd255));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b0, 1'b0, 8'd255, 8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b1, 8'd3,   8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b0, 1'b1, 8'd200, 8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_START, 1'b0, 1'b0, 8'hAA,  8'd255));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'h55,  8'hAA));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'hFF,  8'h55));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b0, 1'b0, 8'd16,  8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd1,   8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_START, 1'b1, 1'b0, 8'd0,   8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd20,  8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b0, 1'b0, 8'd20,  8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_START, 1'b0, 1'b1, 8'd7,   8'd1));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd100, 8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b1, 1'b0, 8'd100, 8'd0));
        directed_q.push_back(make_item(tta_pkg::ACTION_TICK,  1'b0, 1'b0, 8'd100, 8'd0));
        foreach (directed_q[i])
            send_item(directed_q[i]);
        item_ch.valid <= 1'b0;
        wait_idle();

        load_config(32'd0, 32'd0, 32'd0, 32'd0, tta_pkg::NO_LIMIT, tta_pkg::NO_LIMIT, 1'b0);
        run_phase(150, 16, 1'b0);

        // Long tick runs: warn at the soft limit, then five seconds past a zero limit.
        calm = 1'b1;
        load_config(32'd1, 32'd1, 32'd1, 32'd1, 32'd2, 32'd3, 1'b0);
        run_phase(260, 0, 1'b1);
        calm = 1'b0;
        load_config(32'd3, 32'd0, 32'd7, 32'd2, 32'd0, tta_pkg::NO_LIMIT - 1, 1'b0);
        run_phase(260, 0, 1'b0);
        load_config(tta_pkg::NO_LIMIT, tta_pkg::NO_LIMIT, 32'd5, tta_pkg::NO_LIMIT,
                    tta_pkg::NO_LIMIT - 1, 32'd5, 1'b0);
        run_phase(150, 40, 1'b0);

        load_config($urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(1, 12),
                    $urandom_range(0, 12), 32'd1, tta_pkg::NO_LIMIT, 1'b0);
        run_phase(250, 0, 1'b1);

        calm = 1'b1;
        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        run_phase(150, 10, 1'b0);
        calm = 1'b0;

        load_config(32'd0, 32'd4, 32'd2, 32'd3, 32'd0, 32'd0, 1'b1);
        run_phase(100, 12, 1'b0);

        $display("Run: %0d items (%0d task starts), %0d result beats checked, %0d APB writes",
                 sb.items, sb.starts, sb.checked, reg_writes);
        $display("Flags: %0d warn, %0d kill, %0d virtual, %0d profile, %0d reschedule",
                 sb.warns, sb.kills, sb.virt_alarms, sb.prof_alarms, sb.rescheds);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
